>>> rtl/core/wpsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsfd_pkg
// Shared types and constants for the two-wheel state feedback drive core.
// ----------------------------------------------------------------------------
package wpsfd_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int REF_W    = 16;
  localparam int MARGIN_W = 10;
  localparam int GAIN_W   = 24;
  localparam int PULSE_W  = 11;
  localparam int VOLT_W   = 16;
  localparam int MAG_W    = 13;
  localparam int LEN_W    = 9;

  // item modes
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENC_R = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENC_L = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

  // register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_REF_R    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REF_L    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN_R = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN_L = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FF_GAIN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DLY_GAIN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LST_GAIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE   = 3'd7;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd13;

  // completion check steps
  localparam int CHK_W = 3;
  localparam logic [CHK_W-1:0] CHK_NEAR_R   = 3'd0;
  localparam logic [CHK_W-1:0] CHK_NEAR_L   = 3'd1;
  localparam logic [CHK_W-1:0] CHK_ABSREF_R = 3'd2;
  localparam logic [CHK_W-1:0] CHK_PAST_R   = 3'd3;
  localparam logic [CHK_W-1:0] CHK_ABSREF_L = 3'd4;
  localparam logic [CHK_W-1:0] CHK_PAST_L   = 3'd5;
  localparam logic [CHK_W-1:0] CHK_SETTLE_R = 3'd6;
  localparam logic [CHK_W-1:0] CHK_SETTLE_L = 3'd7;

  // pulse conversion: len = floor(m*625/9216) = floor(floor(m*625/1024)*7282/65536)
  localparam logic [PULSE_W-1:0] NEUTRAL   = 11'd1400;
  localparam logic [MAG_W-1:0]   V_MIN     = 13'd3072;
  localparam logic [MAG_W-1:0]   V_MAX     = 13'd6144;
  localparam int                 SCALE_MUL = 625;
  localparam int                 RECIP_9   = 7282;
  localparam int                 VOLT_SHIFT = 6;
  localparam int                 SAT_HI    = 32767;
  localparam int                 SAT_LO    = -32768;

  typedef struct packed {
    logic               drive_valid;
    logic [PULSE_W-1:0] pulse_right;
    logic [PULSE_W-1:0] pulse_left;
    logic               stop;
    logic               active;
  } res_t;

endpackage

>>> rtl/core/wpsfd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsfd channel interfaces
// Valid/ready channels for input items and drive results.
// ----------------------------------------------------------------------------
interface wpsfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [wpsfd_pkg::MODE_W-1:0]  mode;
  logic                          level;

  modport source (output valid, output mode, output level, input ready);
  modport sink   (input valid, input mode, input level, output ready);
endinterface

interface wpsfd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_valid;
  logic [wpsfd_pkg::PULSE_W-1:0] pulse_right;
  logic [wpsfd_pkg::PULSE_W-1:0] pulse_left;
  logic                          stop;
  logic                          active;

  modport source (output valid, output drive_valid, output pulse_right,
                  output pulse_left, output stop, output active, input ready);
  modport sink   (input valid, input drive_valid, input pulse_right,
                  input pulse_left, input stop, input active, output ready);
endinterface

>>> rtl/core/wheel_pair_state_feedback_drive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_pair_state_feedback_drive_core
// Two-side encoder counting and discrete state feedback servo drive.
// ----------------------------------------------------------------------------
// Start and encoder items go from acceptance to the done step and from there
// into the output register, and so does a tick while idle. A tick while active
// first runs eight completion-check steps through one shared subtract,
// magnitude and compare unit; a tick that ends the motion then passes the
// decision step and goes to the done step. A drive tick then runs each side
// through one shared 24 x max(COUNT_BITS,16) multiplier: three products
// accumulated, then saturation, magnitude clamp, scaling by 625 and the
// reciprocal divide by 9, and the pulse. The input is not ready while an item
// is at work; a finished result waits in the output register and does not
// hold up the next item until that item's own result is due.
// ----------------------------------------------------------------------------
module wheel_pair_state_feedback_drive_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  wpsfd_in_if.sink           in_ch,
  wpsfd_out_if.source        out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int MW = (COUNT_BITS > wpsfd_pkg::REF_W) ? COUNT_BITS : wpsfd_pkg::REF_W;
  localparam int CW = MW + 1;
  localparam int PW = wpsfd_pkg::GAIN_W + MW;
  localparam int AW = PW + 2;
  localparam int GW = wpsfd_pkg::GAIN_W;
  localparam int VW = wpsfd_pkg::VOLT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SAT  = 4'd4;
  localparam logic [3:0] S_MAG  = 4'd5;
  localparam logic [3:0] S_SCL  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_PUL  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic signed [AW-1:0] SAT_HI_A = AW'(wpsfd_pkg::SAT_HI);
  localparam logic signed [AW-1:0] SAT_LO_A = AW'(wpsfd_pkg::SAT_LO);

  // configuration registers
  logic [wpsfd_pkg::REF_W-1:0]    ref_right_r, ref_left_r;
  logic [wpsfd_pkg::MARGIN_W-1:0] margin_right_r, margin_left_r, settle_limit_r;
  logic [GW-1:0]                  ff_gain_r, delayed_gain_r, last_gain_r;

  // motion state
  logic [COUNT_BITS-1:0] count_rt_r, count_lt_r;
  logic [COUNT_BITS-1:0] snap_rt_r [3];
  logic [COUNT_BITS-1:0] snap_lt_r [3];
  logic                  level_rt_r, level_lt_r;
  logic                  rev_rt_r, rev_lt_r;
  logic                  running_r;

  // sequencer and datapath
  logic [3:0]                     state_r, state_nxt;
  logic [wpsfd_pkg::CHK_W-1:0]    chk_r;
  logic [1:0]                     mul_ph_r;
  logic                           side_r;
  logic                           near_r, settled_r;
  logic [CW-1:0]                  tmp_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [AW-1:0]           acc_r;
  logic signed [VW-1:0]           volt_r;
  logic [wpsfd_pkg::MAG_W-1:0]    mag_r;
  logic                           neg_r;
  logic [wpsfd_pkg::PULSE_W-1:0]  pulse_rt_r;
  wpsfd_pkg::res_t                res_r, out_data_r;
  logic                           out_valid_r;

  logic in_acc, out_take, out_load, cfg_wr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_right_r    <= '0;
      ref_left_r     <= '0;
      margin_right_r <= wpsfd_pkg::MARGIN_RST;
      margin_left_r  <= wpsfd_pkg::MARGIN_RST;
      ff_gain_r      <= '0;
      delayed_gain_r <= '0;
      last_gain_r    <= '0;
      settle_limit_r <= wpsfd_pkg::MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        wpsfd_pkg::REG_REF_R:    ref_right_r    <= pwdata[wpsfd_pkg::REF_W-1:0];
        wpsfd_pkg::REG_REF_L:    ref_left_r     <= pwdata[wpsfd_pkg::REF_W-1:0];
        wpsfd_pkg::REG_MARGIN_R: margin_right_r <= pwdata[wpsfd_pkg::MARGIN_W-1:0];
        wpsfd_pkg::REG_MARGIN_L: margin_left_r  <= pwdata[wpsfd_pkg::MARGIN_W-1:0];
        wpsfd_pkg::REG_FF_GAIN:  ff_gain_r      <= pwdata[GW-1:0];
        wpsfd_pkg::REG_DLY_GAIN: delayed_gain_r <= pwdata[GW-1:0];
        wpsfd_pkg::REG_LST_GAIN: last_gain_r    <= pwdata[GW-1:0];
        wpsfd_pkg::REG_SETTLE:   settle_limit_r <= pwdata[wpsfd_pkg::MARGIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      wpsfd_pkg::REG_REF_R:    prdata = 32'(ref_right_r);
      wpsfd_pkg::REG_REF_L:    prdata = 32'(ref_left_r);
      wpsfd_pkg::REG_MARGIN_R: prdata = 32'(margin_right_r);
      wpsfd_pkg::REG_MARGIN_L: prdata = 32'(margin_left_r);
      wpsfd_pkg::REG_FF_GAIN:  prdata = 32'(ff_gain_r);
      wpsfd_pkg::REG_DLY_GAIN: prdata = 32'(delayed_gain_r);
      wpsfd_pkg::REG_LST_GAIN: prdata = 32'(last_gain_r);
      wpsfd_pkg::REG_SETTLE:   prdata = 32'(settle_limit_r);
    endcase
  end

  // ---------------------------------------------------------------- check unit
  logic signed [CW-1:0] chk_a, chk_b, chk_diff;
  logic        [CW-1:0] chk_thr, chk_mag;

  always_comb begin
    chk_a   = '0;
    chk_b   = '0;
    chk_thr = '0;
    unique case (chk_r)
      wpsfd_pkg::CHK_NEAR_R: begin
        chk_a   = CW'($signed(count_rt_r));
        chk_b   = CW'($signed(ref_right_r));
        chk_thr = CW'(margin_right_r);
      end
      wpsfd_pkg::CHK_NEAR_L: begin
        chk_a   = CW'($signed(count_lt_r));
        chk_b   = CW'($signed(ref_left_r));
        chk_thr = CW'(margin_left_r);
      end
      wpsfd_pkg::CHK_ABSREF_R: chk_a = CW'($signed(ref_right_r));
      wpsfd_pkg::CHK_PAST_R: begin
        chk_a   = CW'($signed(count_rt_r));
        chk_thr = tmp_r;
      end
      wpsfd_pkg::CHK_ABSREF_L: chk_a = CW'($signed(ref_left_r));
      wpsfd_pkg::CHK_PAST_L: begin
        chk_a   = CW'($signed(count_lt_r));
        chk_thr = tmp_r;
      end
      wpsfd_pkg::CHK_SETTLE_R: begin
        chk_a   = CW'($signed(snap_rt_r[0]));
        chk_b   = CW'($signed(snap_rt_r[1]));
        chk_thr = CW'(settle_limit_r);
      end
      wpsfd_pkg::CHK_SETTLE_L: begin
        chk_a   = CW'($signed(snap_lt_r[0]));
        chk_b   = CW'($signed(snap_lt_r[1]));
        chk_thr = CW'(settle_limit_r);
      end
    endcase
    chk_diff = chk_a - chk_b;
    chk_mag  = chk_diff[CW-1] ? CW'(-chk_diff) : CW'(chk_diff);
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [GW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority case (state_r)
      S_MUL: begin
        unique case (mul_ph_r)
          2'd0: begin
            mul_a = $signed(ff_gain_r);
            mul_b = side_r ? MW'($signed(ref_left_r)) : MW'($signed(ref_right_r));
          end
          2'd1: begin
            mul_a = $signed(delayed_gain_r);
            mul_b = side_r ? MW'($signed(snap_lt_r[2])) : MW'($signed(snap_rt_r[2]));
          end
          2'd2, 2'd3: begin
            mul_a = $signed(last_gain_r);
            mul_b = side_r ? MW'($signed(snap_lt_r[1])) : MW'($signed(snap_rt_r[1]));
          end
        endcase
      end
      S_SCL: begin
        mul_a = GW'(wpsfd_pkg::SCALE_MUL);
        mul_b = MW'(mag_r);
      end
      S_DIV: begin
        // floor(m*625/1024), at most 3750
        mul_a = GW'(wpsfd_pkg::RECIP_9);
        mul_b = MW'(prod_r[21:10]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- voltage path
  logic signed [AW-1:0]         acc_sh;
  logic signed [VW-1:0]         volt_sat;
  logic [VW:0]                  volt_abs;
  logic [wpsfd_pkg::LEN_W-1:0]  pulse_len;
  logic [wpsfd_pkg::PULSE_W-1:0] pulse_val;

  always_comb begin
    acc_sh = acc_r >>> wpsfd_pkg::VOLT_SHIFT;
    priority if (acc_sh > SAT_HI_A) volt_sat = VW'(wpsfd_pkg::SAT_HI);
    else if (acc_sh < SAT_LO_A)     volt_sat = VW'(wpsfd_pkg::SAT_LO);
    else                            volt_sat = acc_sh[VW-1:0];
    volt_abs  = volt_r[VW-1] ? (VW+1)'(-(VW+1)'(volt_r)) : (VW+1)'(volt_r);
    pulse_len = prod_r[24:16];
    pulse_val = neg_r ? wpsfd_pkg::NEUTRAL - wpsfd_pkg::PULSE_W'(pulse_len)
                      : wpsfd_pkg::NEUTRAL + wpsfd_pkg::PULSE_W'(pulse_len);
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        state_nxt = (in_ch.mode == wpsfd_pkg::MODE_TICK && running_r) ? S_CHK : S_DONE;
      end
      S_CHK:  if (chk_r == wpsfd_pkg::CHK_SETTLE_L) state_nxt = S_DEC;
      S_DEC:  state_nxt = (near_r && settled_r) ? S_DONE : S_MUL;
      S_MUL:  if (mul_ph_r == 2'd3) state_nxt = S_SAT;
      S_SAT:  state_nxt = S_MAG;
      S_MAG:  state_nxt = S_SCL;
      S_SCL:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_PUL;
      S_PUL:  state_nxt = side_r ? S_DONE : S_MUL;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      chk_r      <= '0;
      mul_ph_r   <= '0;
      side_r     <= 1'b0;
      count_rt_r <= '0;
      count_lt_r <= '0;
      level_rt_r <= 1'b0;
      level_lt_r <= 1'b0;
      rev_rt_r   <= 1'b0;
      rev_lt_r   <= 1'b0;
      running_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        snap_rt_r[i] <= '0;
        snap_lt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      prod_r  <= mul_a * mul_b;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          res_r.drive_valid <= 1'b0;
          res_r.pulse_right <= wpsfd_pkg::NEUTRAL;
          res_r.pulse_left  <= wpsfd_pkg::NEUTRAL;
          res_r.stop        <= 1'b0;
          res_r.active      <= running_r || (in_ch.mode == wpsfd_pkg::MODE_START);
          chk_r     <= '0;
          near_r    <= 1'b0;
          settled_r <= 1'b0;
          unique case (in_ch.mode)
            wpsfd_pkg::MODE_START: begin
              count_rt_r <= '0;
              count_lt_r <= '0;
              rev_rt_r   <= 1'b0;
              rev_lt_r   <= 1'b0;
              running_r  <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                snap_rt_r[i] <= '0;
                snap_lt_r[i] <= '0;
              end
            end
            wpsfd_pkg::MODE_ENC_R: if (in_ch.level != level_rt_r) begin
              level_rt_r <= in_ch.level;
              count_rt_r <= rev_rt_r ? count_rt_r - COUNT_BITS'(1)
                                     : count_rt_r + COUNT_BITS'(1);
            end
            wpsfd_pkg::MODE_ENC_L: if (in_ch.level != level_lt_r) begin
              level_lt_r <= in_ch.level;
              count_lt_r <= rev_lt_r ? count_lt_r - COUNT_BITS'(1)
                                     : count_lt_r + COUNT_BITS'(1);
            end
            wpsfd_pkg::MODE_TICK: ;
          endcase
        end
        S_CHK: begin
          chk_r <= chk_r + 1'b1;
          unique case (chk_r)
            wpsfd_pkg::CHK_NEAR_R, wpsfd_pkg::CHK_NEAR_L:
              if (chk_mag <= chk_thr) near_r <= 1'b1;
            wpsfd_pkg::CHK_ABSREF_R, wpsfd_pkg::CHK_ABSREF_L:
              tmp_r <= chk_mag;
            wpsfd_pkg::CHK_PAST_R, wpsfd_pkg::CHK_PAST_L:
              if (chk_mag >= chk_thr) near_r <= 1'b1;
            wpsfd_pkg::CHK_SETTLE_R, wpsfd_pkg::CHK_SETTLE_L:
              if (chk_mag < chk_thr) settled_r <= 1'b1;
          endcase
        end
        S_DEC: begin
          side_r   <= 1'b0;
          mul_ph_r <= '0;
          if (near_r && settled_r) begin
            count_rt_r <= '0;
            count_lt_r <= '0;
            rev_rt_r   <= 1'b0;
            rev_lt_r   <= 1'b0;
            running_r  <= 1'b0;
            res_r.stop   <= 1'b1;
            res_r.active <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              snap_rt_r[i] <= '0;
              snap_lt_r[i] <= '0;
            end
          end else begin
            snap_rt_r[2] <= snap_rt_r[1];
            snap_rt_r[1] <= snap_rt_r[0];
            snap_rt_r[0] <= count_rt_r;
            snap_lt_r[2] <= snap_lt_r[1];
            snap_lt_r[1] <= snap_lt_r[0];
            snap_lt_r[0] <= count_lt_r;
          end
        end
        S_MUL: begin
          mul_ph_r <= mul_ph_r + 1'b1;
          // product is registered and lands in the cycle after its operands
          unique case (mul_ph_r)
            2'd0: ;
            2'd1: acc_r <= AW'(prod_r);
            2'd2, 2'd3: acc_r <= acc_r + AW'(prod_r);
          endcase
        end
        S_SAT: volt_r <= volt_sat;
        S_MAG: begin
          neg_r <= volt_r[VW-1];
          if (side_r) rev_lt_r <= volt_r[VW-1];
          else        rev_rt_r <= volt_r[VW-1];
          priority if (volt_abs < (VW+1)'(wpsfd_pkg::V_MIN)) mag_r <= wpsfd_pkg::V_MIN;
          else if (volt_abs > (VW+1)'(wpsfd_pkg::V_MAX))     mag_r <= wpsfd_pkg::V_MAX;
          else mag_r <= volt_abs[wpsfd_pkg::MAG_W-1:0];
        end
        S_SCL, S_DIV: ;
        S_PUL: begin
          mul_ph_r <= '0;
          side_r   <= 1'b1;
          if (side_r) begin
            res_r.drive_valid <= 1'b1;
            res_r.pulse_right <= pulse_rt_r;
            res_r.pulse_left  <= pulse_val;
          end else begin
            pulse_rt_r <= pulse_val;
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res_r;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_valid = out_data_r.drive_valid;
  assign out_ch.pulse_right = out_data_r.pulse_right;
  assign out_ch.pulse_left  = out_data_r.pulse_left;
  assign out_ch.stop        = out_data_r.stop;
  assign out_ch.active      = out_data_r.active;

  // ---------------------------------------------------------------- assertions
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.stop |-> !out_data_r.active && !out_data_r.drive_valid)
    else $error("stop transaction reports active or drive");

  a_drive_off_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.drive_valid |->
      out_data_r.pulse_right != wpsfd_pkg::NEUTRAL &&
      out_data_r.pulse_left != wpsfd_pkg::NEUTRAL && out_data_r.active)
    else $error("drive transaction with neutral pulse or inactive");

  a_stop_only_at_decision: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(running_r) |-> $past(state_r) == S_DEC)
    else $error("motion ended outside the completion decision");

  a_dir_cleared_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> !rev_rt_r && !rev_lt_r)
    else $error("direction bit set while no motion runs");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the done step");

endmodule
